// File: src/waypoint_path_densifier_top_assert.svh
`ifndef WAYPOINT_PATH_DENSIFIER_TOP_ASSERT_SVH
`define WAYPOINT_PATH_DENSIFIER_TOP_ASSERT_SVH
// clocked implication with reset disable
`define WPD_ASSERT(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);
`endif

// File: src/wpd_pkg.sv
`default_nettype none
package wpd_pkg;
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic               path_start;
		logic               path_end;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [15:0] out_heading;
		logic               inserted;
		logic               run_last;
		logic               path_done;
		logic               short_path;
	} out_item_t;

	// classified job handed from front to back
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] h;
		logic               first;
		logic               path_end;
	} job_t;

	localparam logic signed [17:0] PI_Q     = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
	localparam logic [30:0] SPACING_RESET   = 31'd32768;
	localparam logic ADDR_SPACING = 1'b0;
endpackage
`default_nettype wire

// File: src/wpd_front.sv
`default_nettype none
// accepts waypoints and queues them as jobs (two entry fifo)
module wpd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire wpd_pkg::in_item_t in_data,
	output logic                 job_valid,
	input  wire logic            job_ready,
	output wpd_pkg::job_t        job
);
	wpd_pkg::job_t fifo_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          open_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].x        <= in_data.pos_x;
			fifo_q[wr_ptr_q].y        <= in_data.pos_y;
			fifo_q[wr_ptr_q].h        <= in_data.heading;
			fifo_q[wr_ptr_q].first    <= in_data.path_start || !open_q;
			fifo_q[wr_ptr_q].path_end <= in_data.path_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			open_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
				open_q   <= !in_data.path_end;
			end
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: src/wpd_back.sv
`default_nettype none
// computes n, the steps and emits frames
module wpd_back #(
	parameter int MAX_INSERTIONS = 63
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [30:0]   max_spacing,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire wpd_pkg::job_t job,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wpd_pkg::out_item_t out_data
);
	localparam int NW = $clog2(MAX_INSERTIONS + 2);
	localparam logic [NW-1:0] NMAX = NW'(MAX_INSERTIONS);
	localparam int SW = 2 * NW + 62;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_SRCH = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_LAST = 3'd5;

	logic [2:0] state_q;
	logic signed [31:0] prev_x_q, prev_y_q;
	logic signed [15:0] prev_h_q;
	wpd_pkg::job_t job_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [17:0] dh_q;
	logic [32:0] ax_q, ay_q;
	logic [65:0] dsq_q;
	logic [61:0] s2_q;
	logic [NW-1:0] n_q, j_q;
	// n^2 * spacing^2 and the step to (n+1)^2 * spacing^2
	logic [SW-1:0] nsq_q, inc_q;
	// divider: three restoring dividers share one counter
	logic [5:0]  dcnt_q;
	logic [32:0] qx_q, qy_q;
	logic [17:0] qh_q;
	logic [NW:0] rx_q, ry_q, rh_q;
	logic signed [32:0] stx_q, sty_q;
	logic signed [17:0] sth_q;
	logic signed [32:0] accx_q, accy_q;
	logic signed [17:0] acch_q;
	logic [1:0] sqc_q;

	// dx and dy are squared in turn on one shared 33x33 multiplier
	logic [32:0] mul_a;
	logic [65:0] mul_p;
	assign mul_a = (sqc_q == 2'd1) ? ax_q : ay_q;
	assign mul_p = mul_a * mul_a;

	logic        covers;
	assign covers = nsq_q >= SW'(dsq_q);

	logic signed [17:0] dh_raw;
	always_comb begin
		dh_raw = 18'(job.h) - 18'(prev_h_q);
		if (dh_raw > wpd_pkg::PI_Q) dh_raw = dh_raw - wpd_pkg::TWO_PI_Q;
		else if (dh_raw <= -wpd_pkg::PI_Q) dh_raw = dh_raw + wpd_pkg::TWO_PI_Q;
	end

	logic [NW:0] divisor;
	assign divisor = {1'b0, n_q} + {{NW{1'b0}}, 1'b1};

	logic [NW:0] trx, try_, trh;
	always_comb begin
		trx  = {rx_q[NW-1:0], qx_q[32]};
		try_ = {ry_q[NW-1:0], qy_q[32]};
		trh  = {rh_q[NW-1:0], qh_q[17]};
	end

	logic signed [17:0] hsum;
	always_comb begin
		hsum = acch_q + sth_q;
		if (hsum > wpd_pkg::PI_Q) hsum = hsum - wpd_pkg::TWO_PI_Q;
		else if (hsum <= -wpd_pkg::PI_Q) hsum = hsum + wpd_pkg::TWO_PI_Q;
	end

	// first inserted heading: prev plus step, wrapped
	function automatic logic signed [17:0] hsum_first(input logic signed [17:0] p);
		logic signed [17:0] s;
		s = p + (dh_q[17] ? -$signed(qh_q) : $signed(qh_q));
		if (s > wpd_pkg::PI_Q) s = s - wpd_pkg::TWO_PI_Q;
		else if (s <= -wpd_pkg::PI_Q) s = s + wpd_pkg::TWO_PI_Q;
		return s;
	endfunction

	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT) || (state_q == ST_LAST);

	always_comb begin
		out_data = '0;
		if (state_q == ST_LAST) begin
			out_data.out_x       = job_q.x;
			out_data.out_y       = job_q.y;
			out_data.out_heading = job_q.h;
			out_data.run_last    = 1'b1;
			out_data.path_done   = job_q.path_end;
			out_data.short_path  = job_q.first && job_q.path_end;
		end else begin
			out_data.out_x       = accx_q[31:0];
			out_data.out_y       = accy_q[31:0];
			out_data.out_heading = acch_q[15:0];
			out_data.inserted    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (job_valid) begin
				job_q <= job;
				dx_q  <= 33'(job.x) - 33'(prev_x_q);
				dy_q  <= 33'(job.y) - 33'(prev_y_q);
				dh_q  <= dh_raw;
				sqc_q <= 2'd0;
			end
			ST_SQ: begin
				if (sqc_q == 2'd0) begin
					ax_q <= dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
					ay_q <= dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
					s2_q <= max_spacing * max_spacing;
				end else if (sqc_q == 2'd1) begin
					dsq_q <= mul_p;
				end else begin
					dsq_q <= dsq_q + mul_p;
					n_q   <= NW'(1);
					nsq_q <= SW'(s2_q);
					inc_q <= SW'(s2_q) + (SW'(s2_q) << 1);
				end
				sqc_q <= sqc_q + 2'd1;
			end
			ST_SRCH: if (!covers && n_q != NMAX) begin
				n_q   <= n_q + NW'(1);
				nsq_q <= nsq_q + inc_q;
				inc_q <= inc_q + (SW'(s2_q) << 1);
			end else begin
				qx_q <= dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
				qy_q <= dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
				qh_q <= dh_q[17] ? 18'(-dh_q) : 18'(dh_q);
				rx_q <= '0; ry_q <= '0; rh_q <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				dcnt_q <= dcnt_q + 6'd1;
				if (trx >= divisor) begin
					rx_q <= trx - divisor; qx_q <= {qx_q[31:0], 1'b1};
				end else begin
					rx_q <= trx; qx_q <= {qx_q[31:0], 1'b0};
				end
				if (try_ >= divisor) begin
					ry_q <= try_ - divisor; qy_q <= {qy_q[31:0], 1'b1};
				end else begin
					ry_q <= try_; qy_q <= {qy_q[31:0], 1'b0};
				end
				if (dcnt_q < 6'd18) begin
					if (trh >= divisor) begin
						rh_q <= trh - divisor; qh_q <= {qh_q[16:0], 1'b1};
					end else begin
						rh_q <= trh; qh_q <= {qh_q[16:0], 1'b0};
					end
				end
				if (dcnt_q == 6'd32) begin
					stx_q <= dx_q[32] ? -$signed({qx_q[31:0], (trx >= divisor)})
						: $signed({qx_q[31:0], (trx >= divisor)});
					sty_q <= dy_q[32] ? -$signed({qy_q[31:0], (try_ >= divisor)})
						: $signed({qy_q[31:0], (try_ >= divisor)});
					sth_q <= dh_q[17] ? -$signed(qh_q) : $signed(qh_q);
					accx_q <= 33'(prev_x_q)
						+ (dx_q[32] ? -$signed({qx_q[31:0], (trx >= divisor)})
						: $signed({qx_q[31:0], (trx >= divisor)}));
					accy_q <= 33'(prev_y_q)
						+ (dy_q[32] ? -$signed({qy_q[31:0], (try_ >= divisor)})
						: $signed({qy_q[31:0], (try_ >= divisor)}));
					j_q    <= NW'(1);
				end
			end
			default: ;
		endcase
		if (state_q == ST_DIV && dcnt_q == 6'd32) acch_q <= hsum_first(18'(prev_h_q));
		if (state_q == ST_EMIT && out_ready) begin
			accx_q <= accx_q + stx_q;
			accy_q <= accy_q + sty_q;
			acch_q <= hsum;
			j_q    <= j_q + NW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) state_q <= job.first ? ST_LAST : ST_SQ;
				ST_SQ: if (sqc_q == 2'd2) state_q <= ST_SRCH;
				ST_SRCH: if (covers) state_q <= (n_q == NW'(1)) ? ST_LAST : ST_DIV;
					else if (n_q == NMAX) state_q <= ST_DIV;
				ST_DIV: if (dcnt_q == 6'd32) state_q <= ST_EMIT;
				ST_EMIT: if (out_ready && j_q == n_q) state_q <= ST_LAST;
				ST_LAST: if (out_ready) begin
					state_q  <= ST_IDLE;
					prev_x_q <= job_q.x;
					prev_y_q <= job_q.y;
					prev_h_q <= job_q.h;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/waypoint_path_densifier_top.sv
// a path's first waypoint goes straight to its waypoint frame; a waypoint needing no
// frames passes squaring and the linear search for n; otherwise squaring, the search
// and the bit-serial divider come before the n inserted frames and the waypoint frame
// one waypoint in the back end at a time; out_ready can stall each frame
// async reset clears the queue, state machine and previous waypoint and resets spacing
`default_nettype none
module waypoint_path_densifier_top #(
	parameter int MAX_INSERTIONS = 63
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire wpd_pkg::in_item_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output wpd_pkg::out_item_t       out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	logic [30:0] spacing_q;
	logic job_valid, job_ready;
	wpd_pkg::job_t job;

	assign pready = 1'b1;
	assign prdata = (paddr[1] == wpd_pkg::ADDR_SPACING) ? {1'b0, spacing_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) spacing_q <= wpd_pkg::SPACING_RESET;
		else if (psel && penable && pwrite && paddr[1] == wpd_pkg::ADDR_SPACING)
			spacing_q <= pwdata[30:0];
	end

	wpd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	wpd_back #(.MAX_INSERTIONS(MAX_INSERTIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .max_spacing(spacing_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

// File: src/wpd_checker.sv
`default_nettype none
`include "waypoint_path_densifier_top_assert.svh"
module wpd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire wpd_pkg::out_item_t out_data,
	input wire logic pready
);
	`WPD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output dropped")
	`WPD_ASSERT(a_ins_last, clk, arst_n, out_valid |-> !(out_data.inserted && out_data.run_last), "inserted frame marked last")
	`WPD_ASSERT(a_done_last, clk, arst_n, out_valid && out_data.path_done |-> out_data.run_last, "path_done off waypoint")
	`WPD_ASSERT(a_short, clk, arst_n, out_valid && out_data.short_path |-> out_data.path_done, "short path not done")
	`WPD_ASSERT(a_pready, clk, arst_n, pready, "pready low")
endmodule
bind waypoint_path_densifier_top wpd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data), .pready(pready)
);
`default_nettype wire
